// ----- sv/mts_pkg.sv -----
// Package of the min-tracking stack: default sizes, command, status and state codes.
package mts_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned DATA_WIDTH_DEF  = 32;
  localparam int unsigned OCC_W           = 9;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    FSM_IDLE = 1'b0,
    FSM_LOAD = 1'b1
  } fsm_e;

endpackage

// ----- sv/min_tracking_stack.sv -----
// Min-tracking stack: top level with cached stack tops over two stack RAMs.
// A push, or a rejected push or pop, gives its result item in the cycle after accept.
// A successful pop first passes the refill state, while the RAMs refill the tops, then gives its result.
// Throughput: one push per cycle while the output register is empty or being read; a successful
// pop holds the input through the refill state, since the stack RAMs have a registered read port.
// Reset: both counts clear at once; the RAMs are not cleared and need no clearing pass.
module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            s_axis_tvalid,
  output logic                                            s_axis_tready,
  // tdata: push_value
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]                 s_axis_tdata,
  // tuser: cmd
  input  logic [0:0]                                      s_axis_tuser,
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  // tdata: popped_value, min_value, occupancy
  output logic [((2*DATA_WIDTH+mts_pkg::OCC_W+7)/8)*8-1:0] m_axis_tdata,
  // tuser: status (2 bits), min_valid
  output logic [2:0]                                      m_axis_tuser
);

  localparam int unsigned AW          = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned OUT_TDATA_W = ((2*DATA_WIDTH + OCC_W + 7) / 8) * 8;

  // Control state.
  fsm_e             state_q, state_d;
  logic [CNT_W-1:0] main_cnt_q, main_cnt_d;
  logic [CNT_W-1:0] min_cnt_q, min_cnt_d;
  logic             min_pop_q, min_pop_d;
  logic             out_valid_q, out_valid_d;

  // Cached tops of both stacks: the top of the helper stack is the current minimum.
  logic signed [DATA_WIDTH-1:0] main_top_q, main_top_d;
  logic signed [DATA_WIDTH-1:0] min_top_q, min_top_d;
  logic signed [DATA_WIDTH-1:0] popped_q, popped_d;

  // Output register.
  logic [DATA_WIDTH-1:0] out_popped_q, out_popped_d;
  status_e               out_status_q, out_status_d;
  logic                  out_min_valid_q, out_min_valid_d;
  logic [DATA_WIDTH-1:0] out_min_value_q, out_min_value_d;
  logic [OCC_W-1:0]      out_occ_q, out_occ_d;

  logic                         take;
  logic                         is_pop;
  logic signed [DATA_WIDTH-1:0] push_value;
  logic                         main_empty, main_full;
  logic                         min_le, min_room;
  logic                         main_we, min_we;
  logic [DATA_WIDTH-1:0]        main_rdata, min_rdata;
  logic [AW-1:0]                main_raddr, min_raddr;
  logic signed [DATA_WIDTH-1:0] load_min;
  logic                         load_valid;

  assign s_axis_tready = (state_q == FSM_IDLE) && (!out_valid_q || m_axis_tready);
  assign take          = s_axis_tvalid && s_axis_tready;
  assign is_pop        = (s_axis_tuser == CMD_POP);
  assign push_value    = s_axis_tdata[DATA_WIDTH-1:0];

  assign main_empty = (main_cnt_q == '0);
  assign main_full  = (main_cnt_q == CNT_W'(STACK_DEPTH));
  assign min_room   = (min_cnt_q != CNT_W'(STACK_DEPTH));
  // A pushed value joins the helper stack when it ties or beats the current minimum.
  assign min_le     = (min_cnt_q == '0) || (push_value <= min_top_q);

  assign main_we = take && !is_pop && !main_full;
  assign min_we  = main_we && min_le && min_room;

  // A pop reads the entry below each top so the caches can be refilled next cycle.
  // When a stack runs empty the address wraps, and the data read is then never used.
  assign main_raddr = AW'(main_cnt_q - CNT_W'(2));
  assign min_raddr  = AW'(min_cnt_q - CNT_W'(2));

  mts_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .waddr_i (main_cnt_q[AW-1:0]),
    .wdata_i (push_value),
    .raddr_i (main_raddr),
    .rdata_o (main_rdata)
  );

  mts_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (min_we),
    .waddr_i (min_cnt_q[AW-1:0]),
    .wdata_i (push_value),
    .raddr_i (min_raddr),
    .rdata_o (min_rdata)
  );

  // In the refill cycle the counts already hold their values after the pop.
  assign load_min   = min_pop_q ? $signed(min_rdata) : min_top_q;
  assign load_valid = (main_cnt_q != '0) && (min_cnt_q != '0);

  always_comb begin
    state_d         = state_q;
    main_cnt_d      = main_cnt_q;
    min_cnt_d       = min_cnt_q;
    min_pop_d       = min_pop_q;
    main_top_d      = main_top_q;
    min_top_d       = min_top_q;
    popped_d        = popped_q;
    out_valid_d     = out_valid_q && !m_axis_tready;
    out_popped_d    = out_popped_q;
    out_status_d    = out_status_q;
    out_min_valid_d = out_min_valid_q;
    out_min_value_d = out_min_value_q;
    out_occ_d       = out_occ_q;

    case (state_q)
      FSM_IDLE: begin
        if (take) begin
          if (!is_pop) begin
            if (main_full) begin
              // Rejected push: the stack is reported unchanged.
              out_valid_d     = 1'b1;
              out_popped_d    = '0;
              out_status_d    = ST_PUSH_FULL;
              out_min_valid_d = !main_empty && (min_cnt_q != '0);
              out_min_value_d = (!main_empty && (min_cnt_q != '0)) ? min_top_q : '0;
              out_occ_d       = OCC_W'(main_cnt_q);
            end else begin
              main_cnt_d      = main_cnt_q + CNT_W'(1);
              main_top_d      = push_value;
              out_valid_d     = 1'b1;
              out_popped_d    = '0;
              out_status_d    = ST_OK;
              out_min_valid_d = 1'b1;
              out_min_value_d = min_we ? push_value : min_top_q;
              out_occ_d       = OCC_W'(main_cnt_q + CNT_W'(1));
              if (min_we) begin
                min_cnt_d = min_cnt_q + CNT_W'(1);
                min_top_d = push_value;
              end
            end
          end else begin
            if (main_empty) begin
              out_valid_d     = 1'b1;
              out_popped_d    = '0;
              out_status_d    = ST_POP_EMPTY;
              out_min_valid_d = 1'b0;
              out_min_value_d = '0;
              out_occ_d       = OCC_W'(main_cnt_q);
            end else begin
              // The result waits for the refilled tops in the next cycle.
              main_cnt_d = main_cnt_q - CNT_W'(1);
              popped_d   = main_top_q;
              min_pop_d  = (min_cnt_q != '0) && (main_top_q == min_top_q);
              if ((min_cnt_q != '0) && (main_top_q == min_top_q)) begin
                min_cnt_d = min_cnt_q - CNT_W'(1);
              end
              state_d = FSM_LOAD;
            end
          end
        end
      end
      FSM_LOAD: begin
        main_top_d      = main_rdata;
        min_top_d       = load_min;
        out_valid_d     = 1'b1;
        out_popped_d    = popped_q;
        out_status_d    = ST_OK;
        out_min_valid_d = load_valid;
        out_min_value_d = load_valid ? load_min : '0;
        out_occ_d       = OCC_W'(main_cnt_q);
        state_d         = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      main_cnt_q  <= '0;
      min_cnt_q   <= '0;
      min_pop_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      main_cnt_q  <= main_cnt_d;
      min_cnt_q   <= min_cnt_d;
      min_pop_q   <= min_pop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_top_q      <= main_top_d;
    min_top_q       <= min_top_d;
    popped_q        <= popped_d;
    out_popped_q    <= out_popped_d;
    out_status_q    <= out_status_d;
    out_min_valid_q <= out_min_valid_d;
    out_min_value_q <= out_min_value_d;
    out_occ_q       <= out_occ_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_occ_q, out_min_value_q, out_popped_q});
  assign m_axis_tuser  = {out_min_valid_q, out_status_q};

`ifndef SYNTHESIS
  // The helper stack never holds more entries than the main stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni) min_cnt_q <= main_cnt_q)
    else $error("helper stack deeper than main stack");

  // A non-empty main stack always has a minimum on the helper stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_cnt_q != '0 |-> min_cnt_q != '0)
    else $error("main stack holds items but no minimum is tracked");

  // A successful pop always goes through the refill cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && is_pop && !main_empty |=> state_q == FSM_LOAD)
    else $error("pop did not enter the refill cycle");

  // The refill cycle always presents a result item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_LOAD |=> out_valid_q)
    else $error("refill cycle produced no result item");
`endif

endmodule

// ----- sv/mts_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module mts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- tb/tb_min_tracking_stack.sv -----
// Self-checking testbench of the min-tracking stack with its own stack predictor.
`timescale 1ns / 100ps

module tb_min_tracking_stack;
  import mts_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned DW    = DATA_WIDTH_DEF;
  localparam int unsigned S_TDATA_W = ((DW + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((2 * DW + OCC_W + 7) / 8) * 8;

  // Positions of the result fields in m_axis_tdata, lowest field first.
  localparam int unsigned POPPED_LSB = 0;
  localparam int unsigned MINVAL_LSB = DW;
  localparam int unsigned OCC_LSB    = 2 * DW;

  // One stack operation as the driver sends it.
  typedef struct packed {
    cmd_e          cmd;
    logic [DW-1:0] word;
  } stack_op_t;

  // One result item as the block should report it.
  typedef struct packed {
    logic signed [DW-1:0] popped;
    status_e              status;
    logic                 min_valid;
    logic signed [DW-1:0] min_value;
    logic [OCC_W-1:0]     occupancy;
  } stack_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // All inputs of the block start from known values.
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // tdata: push_value
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  // tuser: cmd
  logic [0:0]           s_axis_tuser  = CMD_PUSH;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // tdata: popped_value, min_value, occupancy
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // tuser: status (2 bits), min_valid
  logic [2:0]           m_axis_tuser;

  min_tracking_stack #(
    .STACK_DEPTH(DEPTH),
    .DATA_WIDTH (DW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Operations waiting to be driven, and results still owed by the block.
  stack_op_t     ops_waiting[$];
  stack_result_t results_owed[$];

  // Idling in percent, changed per phase by the stimulus process.
  int unsigned send_idle_pct  = 32;
  int unsigned recv_stall_pct = 61;

  int unsigned ops_issued   = 0;
  int unsigned ops_accepted = 0;
  int unsigned error_count  = 0;
  logic        op_taken     = 1'b0;
  stack_op_t   next_op;

  // The predictor's own copy of both stacks and their depths.
  logic signed [DW-1:0] value_stack[DEPTH];
  logic signed [DW-1:0] floor_stack[DEPTH];
  int unsigned          value_depth = 0;
  int unsigned          floor_depth = 0;

  // Depth as the stimulus generator believes it to be, so that it can steer the
  // stack to full and back to empty.
  int unsigned          planned_depth = 0;

  // Works out the result of one accepted operation and files it as owed.
  task automatic predict_stack_op(input cmd_e cmd, input logic signed [DW-1:0] word);
    stack_result_t res;
    res = '0;
    res.status = ST_OK;
    if (cmd == CMD_PUSH) begin
      if (value_depth >= DEPTH) begin
        res.status = ST_PUSH_FULL;
      end else begin
        value_stack[value_depth] = word;
        value_depth++;
        // The helper stack takes the word when it is a new minimum or a tie,
        // so that a tie survives one pop of an equal value.
        if ((floor_depth == 0 || word <= floor_stack[floor_depth-1]) &&
            floor_depth < DEPTH) begin
          floor_stack[floor_depth] = word;
          floor_depth++;
        end
      end
    end else begin
      if (value_depth == 0) begin
        res.status = ST_POP_EMPTY;
      end else begin
        value_depth--;
        res.popped = value_stack[value_depth];
        if (floor_depth > 0 && res.popped == floor_stack[floor_depth-1]) begin
          floor_depth--;
        end
      end
    end
    if (value_depth > 0 && floor_depth > 0) begin
      res.min_valid = 1'b1;
      res.min_value = floor_stack[floor_depth-1];
    end
    res.occupancy = OCC_W'(value_depth);
    results_owed.push_back(res);
  endtask

  // Compares one received result with the oldest owed result.
  task automatic check_result(input stack_result_t got);
    stack_result_t want;
    if (results_owed.size() == 0) begin
      $display("%0t: unexpected result item: popped %0d status %0d min_valid %0d min %0d occ %0d",
               $time, got.popped, got.status, got.min_valid, got.min_value, got.occupancy);
      error_count++;
      return;
    end
    want = results_owed.pop_front();
    if (got.popped !== want.popped) begin
      $display("%0t: popped_value expected %0d, actual %0d", $time, want.popped, got.popped);
      error_count++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
      error_count++;
    end
    if (got.min_valid !== want.min_valid) begin
      $display("%0t: min_valid expected %0d, actual %0d", $time, want.min_valid,
               got.min_valid);
      error_count++;
    end
    if (got.min_value !== want.min_value) begin
      $display("%0t: min_value expected %0d, actual %0d", $time, want.min_value,
               got.min_value);
      error_count++;
    end
    if (got.occupancy !== want.occupancy) begin
      $display("%0t: occupancy expected %0d, actual %0d", $time, want.occupancy,
               got.occupancy);
      error_count++;
    end
  endtask

  // Driver: inputs change on the falling edge only. A held item stays on the
  // bus until it has been taken, and only then may the sender idle.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || op_taken) begin
        if (ops_waiting.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_op = ops_waiting.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= S_TDATA_W'(next_op.word);
          s_axis_tuser  <= next_op.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: both handshakes are sampled on the rising edge. An accepted
  // operation is predicted at once; its result comes from the output register and is
  // never seen at the same edge, so the owed result is always filed first.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      op_taken <= 1'b0;
    end else begin
      op_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_stack_op(cmd_e'(s_axis_tuser), $signed(s_axis_tdata[DW-1:0]));
        ops_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result('{popped:    m_axis_tdata[POPPED_LSB +: DW],
                       status:    status_e'(m_axis_tuser[1:0]),
                       min_valid: m_axis_tuser[2],
                       min_value: m_axis_tdata[MINVAL_LSB +: DW],
                       occupancy: m_axis_tdata[OCC_LSB +: OCC_W]});
      end
    end
  end

  // Queues one operation and keeps track of the depth it leads to.
  task automatic issue_op(input cmd_e cmd, input logic [DW-1:0] word);
    ops_waiting.push_back('{cmd: cmd, word: word});
    ops_issued++;
    if (cmd == CMD_PUSH && planned_depth < DEPTH) begin
      planned_depth++;
    end else if (cmd == CMD_POP && planned_depth > 0) begin
      planned_depth--;
    end
  endtask

  // Words to push: often a narrow band so that ties and repeated minima are
  // common, some extremes, and the rest spread over the whole word.
  function automatic logic [DW-1:0] pick_word();
    int          band;
    int unsigned pick;
    band = $urandom_range(0, 16);
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      return DW'(band - 8);
    end else if (pick == 4) begin
      case ($urandom_range(0, 3))
        0:       return {1'b0, {(DW-1){1'b1}}};
        1:       return {1'b1, {(DW-1){1'b0}}};
        2:       return '0;
        default: return '1;
      endcase
    end
    return DW'($urandom);
  endfunction

  // A random mix of pushes and pops; a pop carries random data, which the
  // block must ignore.
  task automatic issue_mix(input int unsigned count, input int unsigned push_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < push_pct) begin
        issue_op(CMD_PUSH, pick_word());
      end else begin
        issue_op(CMD_POP, DW'($urandom));
      end
    end
  endtask

  // Blocks until every queued operation has been taken and answered.
  task automatic wait_drained();
    while (ops_accepted != ops_issued || results_owed.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Phase one: the sender idles a third of the time, the receiver stalls often.
    send_idle_pct  = 32;
    recv_stall_pct = 61;

    // Directed opening: pop on an empty stack, then ties, extremes and the
    // minimum being restored as pops unwind the helper stack.
    issue_op(CMD_POP, '1);
    issue_op(CMD_PUSH, DW'(5));
    issue_op(CMD_PUSH, DW'(5));
    issue_op(CMD_PUSH, DW'(7));
    issue_op(CMD_PUSH, {1'b0, {(DW-1){1'b1}}});
    issue_op(CMD_PUSH, {1'b1, {(DW-1){1'b0}}});
    issue_op(CMD_PUSH, '1);
    issue_op(CMD_PUSH, '0);
    repeat (7) issue_op(CMD_POP, '0);
    issue_op(CMD_POP, '0);
    issue_op(CMD_PUSH, {1'b1, {(DW-1){1'b0}}});
    issue_op(CMD_PUSH, {1'b1, {(DW-1){1'b0}}});
    issue_op(CMD_POP, '0);
    issue_op(CMD_POP, '0);
    issue_op(CMD_PUSH, {(DW/2){2'b10}});
    issue_op(CMD_PUSH, {(DW/2){2'b01}});
    issue_op(CMD_POP, {(DW/2){2'b10}});
    issue_op(CMD_POP, '0);

    issue_mix(80, 60);

    // The sender holds off here until every owed result has arrived.
    wait_drained();

    // Phase two: the roles swap. The stack is filled to the top and pushed
    // beyond it, then worked near the top.
    send_idle_pct  = 61;
    recv_stall_pct = 32;
    while (planned_depth < DEPTH) begin
      issue_op(CMD_PUSH, pick_word());
    end
    repeat (4) issue_op(CMD_PUSH, pick_word());
    issue_mix(60, 50);
    wait_drained();

    // Phase three: no idling on either side. Drain to empty, pop past the
    // bottom, then a final mix.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (planned_depth > 0) begin
      issue_op(CMD_POP, DW'($urandom));
    end
    repeat (3) issue_op(CMD_POP, DW'($urandom));
    issue_mix(80, 55);
    wait_drained();

    // A pop passes the refill state; give any stray result time to show up.
    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guards against a hang: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
